// ----- hdl/bsra_pkg.sv -----
// Package: shared widths, register indexes, the star struct and a helper function for the accelerator.
package bsra_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InDataW     = 192;
  localparam int unsigned OutDataW    = 64;
  localparam int unsigned GCapW       = 33;

  typedef enum logic [CfgIdxW-1:0] {
    RegStar1X   = 3'd0,
    RegStar1Y   = 3'd1,
    RegStar2X   = 3'd2,
    RegStar2Y   = 3'd3,
    RegGravPrim = 3'd4,
    RegGravSec  = 3'd5,
    RegOrbit    = 3'd6
  } cfg_reg_e;

  // Star parameters handed to each per-star pipeline.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [30:0] gm;
  } star_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -68'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
    else                                      r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/binary_star_rotating_frame_accel.sv -----
// Top level: configuration registers, pipeline control, final sum and output register.
// Usage:
//   Input beats arrive on s_axis (tdata: active, pos, vel, accel_in) and results
//   leave on m_axis (tdata: accel_out_x, accel_out_y, singular). Star positions,
//   masses and orbit rate are written through cfg_we_i/cfg_idx_i/cfg_data_i while
//   the block is idle.
//   Throughput: one beat per cycle while the output is not stalled.
//   Pipeline: 3 setup stages, 34 root stages, 31+FRAC_BITS and
//   33+FRAC_BITS divider stages for the field strength, 63 for the unit
//   vectors, 3 for the products and sign, and one more for the output
//   register (both stars run in parallel).
//   The whole pipeline advances only when its last stage is empty or is
//   being taken, so a downstream stall freezes every stage; s_axis_tready
//   is high when m_axis_tready is high, the output slot is empty or the last
//   stage is empty.
//   Reset clears the valid bits and all configuration registers to zero.
//   Inactive items carry accel_in through with singular low.
module binary_star_rotating_frame_accel import bsra_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // active[0], pos_x[32:1], pos_y[64:33], vel_x[96:65], vel_y[128:97],
  // accel_in_x[160:129], accel_in_y[192:161], zero fill
  input  logic [199:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // accel_out_x[31:0], accel_out_y[63:32], singular[64], zero fill
  output logic [71:0]         m_axis_tdata
);
  localparam int unsigned StarLat = 3 + 34 + (31 + FRAC_BITS) + (33 + FRAC_BITS) + 63 + 3;
  localparam int unsigned RotLat  = 3;

  logic signed [31:0] s1x_q, s1y_q, s2x_q, s2y_q, w_q;
  logic [30:0] gp_q, gs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1x_q <= '0; s1y_q <= '0; s2x_q <= '0; s2y_q <= '0;
      gp_q <= '0; gs_q <= '0; w_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegStar1X:   s1x_q <= cfg_data_i;
        RegStar1Y:   s1y_q <= cfg_data_i;
        RegStar2X:   s2x_q <= cfg_data_i;
        RegStar2Y:   s2y_q <= cfg_data_i;
        RegGravPrim: gp_q  <= cfg_data_i[30:0];
        RegGravSec:  gs_q  <= cfg_data_i[30:0];
        RegOrbit:    w_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic in_act;
  logic signed [31:0] px, py, vx, vy, aix, aiy;
  assign {aiy, aix, vy, vx, py, px, in_act} = s_axis_tdata[192:0];

  logic en;
  logic out_v_q;
  logic [StarLat-1:0] vld_q;   // vld_q[StarLat-1] is the last stage
  assign en = !vld_q[StarLat-1] || !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[StarLat-2:0], s_axis_tvalid};
  end

  star_cfg_t c1, c2;
  assign c1 = '{pos_x: s1x_q, pos_y: s1y_q, gm: gp_q};
  assign c2 = '{pos_x: s2x_q, pos_y: s2y_q, gm: gs_q};

  logic signed [35:0] p1x, p1y, p2x, p2y;
  logic sg1, sg2;
  bsra_star_pipe #(.FracBits(FRAC_BITS)) u_star1 (
    .clk_i, .en_i(en), .star_i(c1), .pos_x_i(px), .pos_y_i(py),
    .pull_x_o(p1x), .pull_y_o(p1y), .sing_o(sg1));
  bsra_star_pipe #(.FracBits(FRAC_BITS)) u_star2 (
    .clk_i, .en_i(en), .star_i(c2), .pos_x_i(px), .pos_y_i(py),
    .pull_x_o(p2x), .pull_y_o(p2y), .sing_o(sg2));

  logic signed [63:0] rx, ry;
  bsra_rot_pipe #(.FracBits(FRAC_BITS), .Depth(StarLat - RotLat)) u_rot (
    .clk_i, .en_i(en), .w_i(w_q), .pos_x_i(px), .pos_y_i(py),
    .vel_x_i(vx), .vel_y_i(vy), .rot_x_o(rx), .rot_y_o(ry));

  // active flag and accel_in ride alongside
  logic [64:0] side [0:StarLat];
  assign side[0] = {in_act, aix, aiy};
  for (genvar k = 0; k < StarLat; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) side[k+1] <= side[k];
    end
  end
  logic act_l;
  logic signed [31:0] aix_l, aiy_l;
  assign {act_l, aix_l, aiy_l} = side[StarLat];

  logic signed [67:0] sumx, sumy;
  always_comb begin
    sumx = 68'(aix_l);
    sumy = 68'(aiy_l);
    if (act_l) begin
      sumx = sumx + 68'(p1x) + 68'(p2x) + 68'(rx);
      sumy = sumy + 68'(p1y) + 68'(p2y) + 68'(ry);
    end
  end

  logic [64:0] out_q;
  logic take;
  assign take = vld_q[StarLat-1] && en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (take) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (take) out_q <= {act_l && (sg1 || sg2), sat32(sumy), sat32(sumx)};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_q};
endmodule

// ----- hdl/bsra_sqrt_stage.sv -----
// One registered step of a restoring square root plus payload carry.
module bsra_sqrt_stage import bsra_pkg::*; #(
  parameter int unsigned RemW = 68,
  parameter int unsigned Bit  = 0,
  parameter int unsigned PayW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RemW-1:0] s_i,
  input  logic [33:0]     root_i,
  input  logic [PayW-1:0] pay_i,
  output logic [RemW-1:0] s_o,
  output logic [33:0]     root_o,
  output logic [PayW-1:0] pay_o
);
  // Compare the running root candidate squared against S: narrow comparison
  // done incrementally as (root + b)^2 = root^2 + 2*root*b + b^2, kept in s as remainder.
  logic [RemW-1:0] trial;
  logic [RemW-1:0] s_q, s_d;
  logic [33:0]     root_q, root_d;

  always_comb begin
    trial  = ((RemW'(root_i) << (Bit + 1)) | (RemW'(1) << (2 * Bit)));
    s_d    = s_i;
    root_d = root_i;
    if (s_i >= trial) begin
      s_d    = s_i - trial;
      root_d = root_i | (34'd1 << Bit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      root_q <= root_d;
      pay_o  <= pay_i;
    end
  end

  assign s_o    = s_q;
  assign root_o = root_q;
endmodule

// ----- hdl/bsra_div_stage.sv -----
// One registered step of a restoring divider; quotient bits shift in from the bottom.
module bsra_div_stage import bsra_pkg::*; #(
  parameter int unsigned NumW = 64,
  parameter int unsigned PayW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,   // remaining numerator bits, msb first
  input  logic [34:0]     rem_i,
  input  logic [33:0]     den_i,
  input  logic [NumW-1:0] quo_i,
  input  logic [PayW-1:0] pay_i,
  output logic [NumW-1:0] num_o,
  output logic [34:0]     rem_o,
  output logic [33:0]     den_o,
  output logic [NumW-1:0] quo_o,
  output logic [PayW-1:0] pay_o
);
  logic [35:0] sh;
  logic [34:0] rem_d;
  logic        qb;

  always_comb begin
    sh = {rem_i, num_i[NumW-1]};
    qb = (sh >= {2'b0, den_i});
    rem_d = qb ? 35'(sh - {2'b0, den_i}) : sh[34:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= {num_i[NumW-2:0], 1'b0};
      rem_o <= rem_d;
      den_o <= den_i;
      quo_o <= {quo_i[NumW-2:0], qb};
      pay_o <= pay_i;
    end
  end
endmodule

// ----- hdl/bsra_star_pipe.sv -----
// Per-star pull pipeline: offset, squared distance, square root, field strength, axis pulls.
module bsra_star_pipe import bsra_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  star_cfg_t          star_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  output logic signed [35:0] pull_x_o,
  output logic signed [35:0] pull_y_o,
  output logic               sing_o
);
  localparam int unsigned NumG1 = 31 + FracBits;
  localparam int unsigned NumU  = 33 + 30;
  localparam int unsigned PayW  = 33 + 33 + 2;

  // stage 1: offsets and magnitudes
  logic signed [32:0] dx_q, dy_q;
  logic [30:0] gm_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= 33'(pos_x_i) - 33'(star_i.pos_x);
      dy_q <= 33'(pos_y_i) - 33'(star_i.pos_y);
      gm_q <= star_i.gm;
    end
  end
  logic [32:0] ax, ay;
  assign ax = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ay = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

  // stage 2: squares
  logic [65:0] sqx_q, sqy_q;
  logic signed [32:0] dx2_q, dy2_q;
  logic [30:0] gm2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= 66'(ax) * 66'(ax);
      sqy_q <= 66'(ay) * 66'(ay);
      dx2_q <= dx_q; dy2_q <= dy_q; gm2_q <= gm_q;
    end
  end

  // stage 3: sum
  logic [67:0] s_q;
  logic signed [32:0] dx3_q, dy3_q;
  logic [30:0] gm3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= 68'(sqx_q) + 68'(sqy_q);
      dx3_q <= dx2_q; dy3_q <= dy2_q; gm3_q <= gm2_q;
    end
  end

  // square root, one bit per stage
  localparam int unsigned SqPay = 33 + 33 + 31 + 1;
  logic [67:0] sr_s [0:34];
  logic [33:0] sr_r [0:34];
  logic [SqPay-1:0] sr_p [0:34];
  assign sr_s[0] = s_q;
  assign sr_r[0] = '0;
  assign sr_p[0] = {dx3_q, dy3_q, gm3_q, (s_q == '0)};
  for (genvar k = 0; k < 34; k++) begin : g_sqrt
    bsra_sqrt_stage #(.RemW(68), .Bit(33 - k), .PayW(SqPay)) u_st (
      .clk_i, .en_i, .s_i(sr_s[k]), .root_i(sr_r[k]), .pay_i(sr_p[k]),
      .s_o(sr_s[k+1]), .root_o(sr_r[k+1]), .pay_o(sr_p[k+1]));
  end

  logic [33:0] sq_root;
  logic signed [32:0] dxs, dys;
  logic [30:0] gms;
  logic sings;
  assign sq_root = sr_r[34];
  assign {dxs, dys, gms, sings} = sr_p[34];
  // divisor for zero distance forced to 1; result discarded anyway
  logic [33:0] den;
  assign den = sings ? 34'd1 : sq_root;

  // first quotient: (gm << F) / D
  localparam int unsigned P1W = 33 + 33 + 1;
  logic [NumG1-1:0] a_num [0:NumG1];
  logic [34:0] a_rem [0:NumG1];
  logic [33:0] a_den [0:NumG1];
  logic [NumG1-1:0] a_quo [0:NumG1];
  logic [P1W-1:0] a_pay [0:NumG1];
  assign a_num[0] = {gms, FracBits'(0)};
  assign a_rem[0] = '0;
  assign a_den[0] = den;
  assign a_quo[0] = '0;
  assign a_pay[0] = {dxs, dys, sings};
  for (genvar k = 0; k < NumG1; k++) begin : g_div1
    bsra_div_stage #(.NumW(NumG1), .PayW(P1W)) u_d (
      .clk_i, .en_i, .num_i(a_num[k]), .rem_i(a_rem[k]), .den_i(a_den[k]),
      .quo_i(a_quo[k]), .pay_i(a_pay[k]), .num_o(a_num[k+1]), .rem_o(a_rem[k+1]),
      .den_o(a_den[k+1]), .quo_o(a_quo[k+1]), .pay_o(a_pay[k+1]));
  end

  // clamp q to 33 bits; flag carries the cap
  logic [NumG1-1:0] q1;
  logic q1_cap;
  logic [32:0] q1c;
  assign q1 = a_quo[NumG1];
  assign q1_cap = (q1 > NumG1'(34'h1_FFFF_FFFF));
  assign q1c = q1_cap ? 33'h1_FFFF_FFFF : q1[32:0];

  // second quotient: (q << F) / D
  localparam int unsigned NumG2 = 33 + FracBits;
  localparam int unsigned P2W = 33 + 33 + 2;
  logic [NumG2-1:0] b_num [0:NumG2];
  logic [34:0] b_rem [0:NumG2];
  logic [33:0] b_den [0:NumG2];
  logic [NumG2-1:0] b_quo [0:NumG2];
  logic [P2W-1:0] b_pay [0:NumG2];
  assign b_num[0] = {q1c, FracBits'(0)};
  assign b_rem[0] = '0;
  assign b_den[0] = a_den[NumG1];
  assign b_quo[0] = '0;
  assign b_pay[0] = {a_pay[NumG1], q1_cap};
  for (genvar k = 0; k < NumG2; k++) begin : g_div2
    bsra_div_stage #(.NumW(NumG2), .PayW(P2W)) u_d (
      .clk_i, .en_i, .num_i(b_num[k]), .rem_i(b_rem[k]), .den_i(b_den[k]),
      .quo_i(b_quo[k]), .pay_i(b_pay[k]), .num_o(b_num[k+1]), .rem_o(b_rem[k+1]),
      .den_o(b_den[k+1]), .quo_o(b_quo[k+1]), .pay_o(b_pay[k+1]));
  end

  logic [NumG2-1:0] q2;
  logic signed [32:0] dxg, dyg;
  logic sg, capg;
  logic [32:0] g;
  assign q2 = b_quo[NumG2];
  assign {dxg, dyg, sg, capg} = b_pay[NumG2];
  assign g = (capg || q2 > NumG2'(34'h1_FFFF_FFFF)) ? 33'h1_FFFF_FFFF : q2[32:0];

  // unit vectors: |d| << 30 / D for both axes in parallel
  logic [32:0] mx, my;
  assign mx = dxg[32] ? 33'(-dxg) : 33'(dxg);
  assign my = dyg[32] ? 33'(-dyg) : 33'(dyg);
  localparam int unsigned PuW = 33 + 2 + 1;
  logic [NumU-1:0] xn [0:NumU], yn [0:NumU], xq [0:NumU], yq [0:NumU];
  logic [34:0] xr [0:NumU], yr [0:NumU];
  logic [33:0] xd [0:NumU], yd [0:NumU];
  logic [PuW-1:0] xp [0:NumU];
  logic [0:0] yp [0:NumU];
  assign xn[0] = {mx, 30'd0};
  assign yn[0] = {my, 30'd0};
  assign xr[0] = '0; assign yr[0] = '0;
  assign xq[0] = '0; assign yq[0] = '0;
  assign xd[0] = b_den[NumG2]; assign yd[0] = b_den[NumG2];
  assign xp[0] = {g, dxg[32], dyg[32], sg};
  assign yp[0] = 1'b0;
  for (genvar k = 0; k < NumU; k++) begin : g_divu
    bsra_div_stage #(.NumW(NumU), .PayW(PuW)) u_dx (
      .clk_i, .en_i, .num_i(xn[k]), .rem_i(xr[k]), .den_i(xd[k]),
      .quo_i(xq[k]), .pay_i(xp[k]), .num_o(xn[k+1]), .rem_o(xr[k+1]),
      .den_o(xd[k+1]), .quo_o(xq[k+1]), .pay_o(xp[k+1]));
    bsra_div_stage #(.NumW(NumU), .PayW(1)) u_dy (
      .clk_i, .en_i, .num_i(yn[k]), .rem_i(yr[k]), .den_i(yd[k]),
      .quo_i(yq[k]), .pay_i(yp[k]), .num_o(yn[k+1]), .rem_o(yr[k+1]),
      .den_o(yd[k+1]), .quo_o(yq[k+1]), .pay_o(yp[k+1]));
  end

  // u fits in 31 bits (|d| <= D)
  logic [32:0] gu;
  logic negx, negy, su;
  assign {gu, negx, negy, su} = xp[NumU];

  // g*u: 33x31 split in two partial products over two stages
  logic [63:0] plx_q, ply_q, phx_q, phy_q;
  logic [32:0] g5_q;
  logic nx5_q, ny5_q, s5_q;
  logic [14:0] uxh_q, uyh_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plx_q <= 64'(gu) * 64'(xq[NumU][15:0]);
      ply_q <= 64'(gu) * 64'(yq[NumU][15:0]);
      uxh_q <= xq[NumU][30:16];
      uyh_q <= yq[NumU][30:16];
      g5_q  <= gu;
      nx5_q <= negx; ny5_q <= negy; s5_q <= su;
    end
  end
  logic [63:0] plx6_q, ply6_q;
  logic nx6_q, ny6_q, s6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phx_q  <= 64'(g5_q) * 64'(uxh_q);
      phy_q  <= 64'(g5_q) * 64'(uyh_q);
      plx6_q <= plx_q; ply6_q <= ply_q;
      nx6_q <= nx5_q; ny6_q <= ny5_q; s6_q <= s5_q;
    end
  end
  logic [64:0] px, py;
  logic [34:0] cx, cy;
  assign px = 65'(plx6_q) + (65'(phx_q) << 16);
  assign py = 65'(ply6_q) + (65'(phy_q) << 16);
  assign cx = px[64:30];
  assign cy = py[64:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // positive offset pulls negative; zero offset gives zero anyway
      pull_x_o <= s6_q ? '0 : (nx6_q ? 36'(cx) : -36'(cx));
      pull_y_o <= s6_q ? '0 : (ny6_q ? 36'(cy) : -36'(cy));
      sing_o   <= s6_q;
    end
  end
endmodule

// ----- hdl/bsra_rot_pipe.sv -----
// Rotation terms, delayed to match the star pipelines.
module bsra_rot_pipe import bsra_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned Depth    = 8
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] w_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  output logic signed [63:0] rot_x_o,
  output logic signed [63:0] rot_y_o
);
  logic signed [63:0] mx_q, my_q;
  logic signed [31:0] w1_q, vx1_q, vy1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q <= 64'(w_i) * 64'(pos_x_i);
      my_q <= 64'(w_i) * 64'(pos_y_i);
      w1_q <= w_i; vx1_q <= vel_x_i; vy1_q <= vel_y_i;
    end
  end
  logic signed [31:0] ix_q, iy_q, w2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // arithmetic shift is floor
      ix_q <= sat32(68'(mx_q >>> FracBits) + 68'(vy1_q) * 68'sd2);
      iy_q <= sat32(68'(my_q >>> FracBits) - 68'(vx1_q) * 68'sd2);
      w2_q <= w1_q;
    end
  end
  logic signed [63:0] rx_q, ry_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q <= (64'(w2_q) * 64'(ix_q)) >>> FracBits;
      ry_q <= (64'(w2_q) * 64'(iy_q)) >>> FracBits;
    end
  end
  logic signed [63:0] dlx [0:Depth];
  logic signed [63:0] dly [0:Depth];
  assign dlx[0] = rx_q;
  assign dly[0] = ry_q;
  for (genvar k = 0; k < Depth; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dlx[k+1] <= dlx[k];
        dly[k+1] <= dly[k];
      end
    end
  end
  assign rot_x_o = dlx[Depth];
  assign rot_y_o = dly[Depth];
endmodule

// ----- hdl/bsra_checker.sv -----
// Port-level checker for the accelerator, bound to the top level.
module bsra_checker import bsra_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:65] == '0)
    else $error("fill bits set");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("valid out of reset");
endmodule

bind binary_star_rotating_frame_accel bsra_checker u_bsra_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

// ----- dv/binary_star_rotating_frame_accel_test.sv -----
// Testbench for the binary-star rotating-frame accel: directed, random, back-pressure beats.
module binary_star_rotating_frame_accel_test;
  import bsra_pkg::*;

  localparam int unsigned Frac = 16;
  localparam int unsigned Latency = 2 * (31 + Frac) + 65 + 34 + 3 + 4;
  localparam logic [32:0] GCap = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic        [31:0] ay;
    logic        [31:0] ax;
    logic        [31:0] vy;
    logic        [31:0] vx;
    logic        [31:0] py;
    logic        [31:0] px;
    logic               active;
  } particle_t;

  typedef struct packed {
    logic        sing;
    logic [31:0] ay;
    logic [31:0] ax;
  } accel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  binary_star_rotating_frame_accel dut (.*);

  // local copy of the registers
  logic signed [31:0] s1x, s1y, s2x, s2y, omega;
  logic [30:0] gm1, gm2;

  accel_t expected_accel[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;

  initial forever #2 clk_i = ~clk_i;

  function automatic logic signed [63:0] sat_32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic [33:0] root_floor(input logic [65:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({66'd0, c} * {66'd0, c} <= {66'd0, s}) r = c;
    end
    return r;
  endfunction

  // adds one star's pull; returns 1 when the particle sits on the star
  function automatic bit add_pull(input logic signed [63:0] dx, input logic signed [63:0] dy,
                                  input logic [30:0] gm, inout logic signed [63:0] sx,
                                  inout logic signed [63:0] sy);
    logic [127:0] mx, my, span, q, g, u;
    logic [65:0] ss;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    ss = mx * mx + my * my;
    if (ss == 0) return 1'b1;
    span = root_floor(ss);
    q = ({97'd0, gm} << Frac) / span;
    if (q > GCap) g = GCap;
    else begin
      g = (q << Frac) / span;
      if (g > GCap) g = GCap;
    end
    u = (mx << 30) / span;
    if (dx > 0) sx -= 64'((g * u) >> 30); else sx += 64'((g * u) >> 30);
    u = (my << 30) / span;
    if (dy > 0) sy -= 64'((g * u) >> 30); else sy += 64'((g * u) >> 30);
    return 1'b0;
  endfunction

  function automatic accel_t predict_accel(input particle_t p);
    logic signed [63:0] px, py, vx, vy, sx, sy, w, inner;
    accel_t r;
    px = signed'(p.px); py = signed'(p.py);
    vx = signed'(p.vx); vy = signed'(p.vy);
    sx = signed'(p.ax); sy = signed'(p.ay);
    w = omega;
    r.sing = 1'b0;
    if (p.active) begin
      if (add_pull(px - s1x, py - s1y, gm1, sx, sy)) r.sing = 1'b1;
      if (add_pull(px - s2x, py - s2y, gm2, sx, sy)) r.sing = 1'b1;
      inner = sat_32(((w * px) >>> Frac) + 2 * vy);
      sx += (w * inner) >>> Frac;
      inner = sat_32(((w * py) >>> Frac) - 2 * vx);
      sy += (w * inner) >>> Frac;
    end
    r.ax = sat_32(sx);
    r.ay = sat_32(sy);
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegStar1X:   s1x = val;
      RegStar1Y:   s1y = val;
      RegStar2X:   s2x = val;
      RegStar2Y:   s2y = val;
      RegGravPrim: gm1 = val[30:0];
      RegGravSec:  gm2 = val[30:0];
      RegOrbit:    omega = val;
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [31:0] ax, ay, bx, by, g1, g2, w);
    write_reg(RegStar1X, ax);
    write_reg(RegStar1Y, ay);
    write_reg(RegStar2X, bx);
    write_reg(RegStar2Y, by);
    write_reg(RegGravPrim, g1);
    write_reg(RegGravSec, g2);
    write_reg(RegOrbit, w);
  endtask

  // tvalid stays up after the beat; drain() or an idle gap in the next call lowers it
  task automatic send_particle(input particle_t p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, p};
    expected_accel.push_back(predict_accel(p));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_accel.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word;
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(20)) - 10);
      3: return 32'(signed'($urandom_range(400000)) - 200000) << 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle;
    particle_t p;
    p.active = $urandom_range(9) != 0;
    p.px = rand_word(); p.py = rand_word();
    p.vx = rand_word(); p.vy = rand_word();
    p.ax = rand_word(); p.ay = rand_word();
    if ($urandom_range(19) == 0) begin
      p.px = $urandom_range(1) ? s1x : s2x;
      p.py = p.px == s1x ? s1y : s2y;
    end
    return p;
  endfunction

  // m_axis checker and receiver stall
  always @(posedge clk_i) begin
    accel_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[64:0];
      results_seen++;
      if (expected_accel.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_accel.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h s=%b, got x=%h y=%h s=%b",
                     want.ax, want.ay, want.sing, got.ax, got.ay, got.sing);
        end
      end
    end
    m_axis_tready <= !hold_off && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  task automatic test_directed;
    particle_t p;
    set_frame(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0002_0000,
              32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
    p = '0;
    send_particle(p);                       // inactive passes through
    p.ax = 32'h7FFF_FFFF; p.ay = 32'h8000_0000;
    send_particle(p);
    p.active = 1'b1; p.px = 32'h0001_0000; p.py = '0;   // on primary
    send_particle(p);
    p.px = 32'hFFFF_0000; p.py = 32'h0002_0000;          // on secondary
    send_particle(p);
    p.px = 32'h7FFF_FFFF; p.py = 32'h8000_0000;
    p.vx = 32'h8000_0000; p.vy = 32'h7FFF_FFFF;
    send_particle(p);
    p.px = 32'h0001_0001; p.py = 32'h0; p.vx = 0; p.vy = 0; p.ax = 0; p.ay = 0;
    send_particle(p);                        // very close: capped field
    drain();
    set_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    p = '1;
    send_particle(p);
    p.px = 32'h8000_0000; p.py = 32'h7FFF_FFFF;
    send_particle(p);
    p.px = 32'h7FFF_FFFF; p.py = 32'h8000_0000;
    send_particle(p);
    p.px = 0; p.py = 0; p.vx = 32'h7FFF_FFFF; p.vy = 32'h8000_0000;
    send_particle(p);
    drain();
    set_frame(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
    p.px = 0; p.py = 0;
    send_particle(p);                        // on both stars at once
    p.px = 32'h7FFF_FFFF; p.py = 32'h7FFF_FFFF;
    send_particle(p);
    drain();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle,
                             input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_frame(rand_word(), rand_word(), rand_word(), rand_word(),
              $urandom, $urandom, rand_word());
    repeat (count) send_particle(rand_particle());
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // output held off while 300 beats are offered: the pipeline fills
  task automatic test_backpressure;
    hold_off <= 1'b1;
    fork
      repeat (300) send_particle(rand_particle());
      begin
        repeat (600) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    s1x = 0; s1y = 0; s2x = 0; s2y = 0; gm1 = 0; gm2 = 0; omega = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400, 0, 0);
    test_random(400, 65, 0);
    test_random(400, 0, 65);
    test_random(400, 15, 15);
    test_backpressure();
    repeat (Latency + 20) @(posedge clk_i);
    $display("Covered directed corners, four idle/stall mixes with varied star setups and a");
    $display("long output hold-off; %0d result beats checked.", results_seen);
    if (mismatches == 0 && expected_accel.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d missing", mismatches, expected_accel.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- binary_star_rotating_frame_accel.f -----
hdl/bsra_pkg.sv
hdl/bsra_sqrt_stage.sv
hdl/bsra_div_stage.sv
hdl/bsra_star_pipe.sv
hdl/bsra_rot_pipe.sv
hdl/binary_star_rotating_frame_accel.sv
hdl/bsra_checker.sv
dv/binary_star_rotating_frame_accel_test.sv
